// ===== src/bis_pkg.sv =====
`timescale 1ns / 1ps

package bis_pkg;

  localparam int DEPTH  = 64;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 6;
  localparam int LVL_W  = 7;
  localparam int REQ_W  = 3;

  // Request codes as they arrive on req_type.
  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH   = 3'd0,
    REQ_POP    = 3'd1,
    REQ_PEEK   = 3'd2,
    REQ_CLEAR  = 3'd3,
    REQ_SEARCH = 3'd4
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_SCAN,
    ST_RESULT
  } state_t;

  // Conditions reported by the datapath to the sequencer.
  typedef struct packed {
    logic             in_valid;
    logic [REQ_W-1:0] req;
    logic             cnt_zero;
    logic             cnt_lt_cap;
    logic             match;
    logic             idx_zero;
    logic             out_free;
  } sts_t;

  // Actions the sequencer asks of the datapath.
  typedef struct packed {
    logic in_stall;
    logic accept;
    logic wr_en;
    logic cnt_inc;
    logic cnt_dec;
    logic cnt_clr;
    logic rd_top;
    logic rd_scan;
    logic idx_load;
    logic idx_dec;
    logic res_fail;
    logic res_ok;
    logic res_data;
    logic res_found;
    logic out_load;
  } ctl_t;

endpackage

// ===== src/bis_ram.sv =====
`timescale 1ns / 1ps

module bis_ram
  import bis_pkg::*;
(
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/bis_ctrl.sv =====
`timescale 1ns / 1ps

module bis_ctrl
  import bis_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  sts_t   sts,
  output ctl_t   ctl,
  output state_t state
);

  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (sts.in_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (sts.req)
          REQ_POP, REQ_PEEK: begin
            state_next = sts.cnt_zero ? ST_RESULT : ST_READ;
          end
          REQ_SEARCH: begin
            state_next = sts.cnt_zero ? ST_RESULT : ST_SCAN;
          end
          default: begin
            state_next = ST_RESULT;
          end
        endcase
      end
      ST_READ: begin
        state_next = ST_RESULT;
      end
      ST_SCAN: begin
        if (sts.match || sts.idx_zero) begin
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (sts.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ctl = '0;
    ctl.in_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        ctl.in_stall = 1'b0;
        ctl.accept   = sts.in_valid;
      end
      ST_EXEC: begin
        case (sts.req)
          REQ_PUSH: begin
            if (sts.cnt_lt_cap) begin
              ctl.wr_en   = 1'b1;
              ctl.cnt_inc = 1'b1;
              ctl.res_ok  = 1'b1;
            end else begin
              ctl.res_fail = 1'b1;
            end
          end
          REQ_POP: begin
            if (sts.cnt_zero) begin
              ctl.res_fail = 1'b1;
            end else begin
              ctl.rd_top  = 1'b1;
              ctl.cnt_dec = 1'b1;
            end
          end
          REQ_PEEK: begin
            if (sts.cnt_zero) begin
              ctl.res_fail = 1'b1;
            end else begin
              ctl.rd_top = 1'b1;
            end
          end
          REQ_CLEAR: begin
            ctl.cnt_clr = 1'b1;
            ctl.res_ok  = 1'b1;
          end
          REQ_SEARCH: begin
            if (sts.cnt_zero) begin
              ctl.res_fail = 1'b1;
            end else begin
              ctl.rd_top   = 1'b1;
              ctl.idx_load = 1'b1;
            end
          end
          default: begin
            ctl.res_fail = 1'b1;
          end
        endcase
      end
      ST_READ: begin
        ctl.res_data = 1'b1;
      end
      ST_SCAN: begin
        if (sts.match) begin
          ctl.res_found = 1'b1;
        end else if (sts.idx_zero) begin
          ctl.res_fail = 1'b1;
        end else begin
          ctl.idx_dec = 1'b1;
          ctl.rd_scan = 1'b1;
        end
      end
      ST_RESULT: begin
        ctl.out_load = sts.out_free;
      end
      default: begin
        ctl.in_stall = 1'b1;
      end
    endcase
  end

endmodule

// ===== src/bounded_integer_stack.sv =====
`timescale 1ns / 1ps

// Channel   | Direction | Handshake          | Word
// ----------+-----------+--------------------+-------------------------------------------
// request   | in        | in_valid/in_stall  | req_type, value
// result    | out       | out_valid/out_stall| status, data_out, position, level,
//           |           |                    | is_empty, is_full
// capacity  | in        | cfg_we             | cfg_data
//
// Push, clear and rejected requests go from the execute state to the result state, which
// loads out_valid; pop and peek add a read state, as the entry RAM has a registered read.
// Search adds a scan state: the RAM and one comparator walk one entry per cycle from the top
// down, comparing at most level entries; no request is taken until the last result loads.
// Reset (rst, synchronous) empties the stack and sets capacity to 64; entries keep data.
// A stalled result holds the sequencer in its result state and the request channel stalls.

module bounded_integer_stack
  import bis_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [REQ_W-1:0]         req_type,
  input  logic signed [DATA_W-1:0] value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     status,
  output logic signed [DATA_W-1:0] data_out,
  output logic [ADDR_W-1:0]        position,
  output logic [LVL_W-1:0]         level,
  output logic                     is_empty,
  output logic                     is_full,
  input  logic                     cfg_we,
  input  logic [LVL_W-1:0]         cfg_data
);

  // Latched request word.
  logic [REQ_W-1:0]  req_reg;
  logic [DATA_W-1:0] val_reg;

  // Stack level and capacity register.
  logic [LVL_W-1:0]  count;
  logic [LVL_W-1:0]  cap_reg;
  logic [LVL_W-1:0]  eff_cap;
  logic [LVL_W-1:0]  count_m1;

  // Search index: the entry whose data arrives from the RAM this cycle.
  logic [ADDR_W-1:0] idx;
  logic [ADDR_W-1:0] idx_m1;

  // Result held until the output register is free.
  logic              res_status;
  logic [DATA_W-1:0] res_data;
  logic [ADDR_W-1:0] res_pos;

  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [DATA_W-1:0] rd_data;

  sts_t   sts;
  ctl_t   ctl;
  state_t state;

  // A capacity above the RAM depth saturates to the depth.
  assign eff_cap  = (cap_reg > LVL_W'(DEPTH)) ? LVL_W'(DEPTH) : cap_reg;
  assign count_m1 = count - LVL_W'(1);
  assign idx_m1   = idx - ADDR_W'(1);

  // Top reads use the level before any pop decrement takes effect. During a
  // search the next lower entry is fetched while the current one is compared.
  assign rd_en   = ctl.rd_top | ctl.rd_scan;
  assign rd_addr = ctl.rd_scan ? idx_m1 : count_m1[ADDR_W-1:0];

  assign sts.in_valid   = in_valid;
  assign sts.req        = req_reg;
  assign sts.cnt_zero   = (count == '0);
  assign sts.cnt_lt_cap = (count < eff_cap);
  assign sts.match      = (rd_data == val_reg);
  assign sts.idx_zero   = (idx == '0);
  assign sts.out_free   = ~out_valid | ~out_stall;

  assign in_stall = ctl.in_stall;

  bis_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .sts   (sts),
    .ctl   (ctl),
    .state (state)
  );

  bis_ram u_ram (
    .clk     (clk),
    .wr_en   (ctl.wr_en),
    .wr_addr (count[ADDR_W-1:0]),
    .wr_data (val_reg),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      req_reg <= req_type;
      val_reg <= value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_reg <= LVL_W'(DEPTH);
    end else if (cfg_we) begin
      cap_reg <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.cnt_clr) begin
      count <= '0;
    end else if (ctl.cnt_inc) begin
      count <= count + LVL_W'(1);
    end else if (ctl.cnt_dec) begin
      count <= count_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.idx_load) begin
      idx <= count_m1[ADDR_W-1:0];
    end else if (ctl.idx_dec) begin
      idx <= idx_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.res_fail || ctl.res_ok) begin
      res_status <= ctl.res_fail;
      res_data   <= '0;
      res_pos    <= '0;
    end else if (ctl.res_data) begin
      res_status <= 1'b0;
      res_data   <= rd_data;
      res_pos    <= '0;
    end else if (ctl.res_found) begin
      res_status <= 1'b0;
      res_data   <= '0;
      res_pos    <= idx;
    end
  end

  // The level is final once the sequencer reaches its result state.
  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      status   <= res_status;
      data_out <= res_data;
      position <= res_pos;
      level    <= count;
      is_empty <= (count == '0);
      is_full  <= (count >= eff_cap);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid <= 1'b1;
    end else if (~out_stall) begin
      out_valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    ctl.wr_en |-> (count < eff_cap))
    else $error("push writes past capacity");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    ctl.out_load |-> (!out_valid || !out_stall))
    else $error("result overwrites a stalled word");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request taken while busy");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> ({1'b0, idx} < count))
    else $error("search index outside held entries");
`endif

endmodule
